// ----- sv/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers; they compile to nothing when SYNTH is set.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// check a property at each rising edge outside reset
`define PIE_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("assertion failed");
// check that a condition never holds outside reset
`define PIE_NEVER(lbl, clk, rstn, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
    else $error("forbidden condition seen");
`else
`define PIE_ASSERT(lbl, clk, rstn, prop)
`define PIE_NEVER(lbl, clk, rstn, cond)
`endif
`endif

// ----- sv/pie_pkg.sv -----
// ----------------------------------------------------------------------------
// pie_pkg
// Shared types, codes and helpers of the pot and index zeroing estimator.
// ----------------------------------------------------------------------------
`default_nettype none

package pie_pkg;

  localparam int POS_W       = 32;
  localparam int SAT_W       = POS_W + 4;
  localparam int DEF_MAX_AVG = 64;
  localparam int CFG_AW      = 4;

  // register reset values
  localparam logic [6:0]  RST_AVG_COUNT = 7'd16;
  localparam logic [30:0] RST_SPACING   = 31'd411775;
  localparam logic [31:0] RST_LOCATION  = 32'd0;
  localparam logic [30:0] RST_ERR_LIMIT = 31'd41177;

  typedef enum logic [1:0] {
    OP_SAMPLE  = 2'd0,
    OP_ERROR   = 2'd1,
    OP_RESTART = 2'd2,
    OP_NONE    = 2'd3
  } pie_op_t;

  typedef enum logic [1:0] {
    REG_AVG_COUNT = 2'd0,
    REG_SPACING   = 2'd1,
    REG_LOCATION  = 2'd2,
    REG_ERR_LIMIT = 2'd3
  } pie_reg_t;

  typedef enum logic [1:0] {
    DIV_MOD  = 2'd0,
    DIV_AVG  = 2'd1,
    DIV_SNAP = 2'd2
  } pie_div_sel_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHECK,
    ST_MOD_GO,
    ST_MOD_WAIT,
    ST_READ,
    ST_UPDATE,
    ST_AVG_GO,
    ST_AVG_WAIT,
    ST_AVG_END,
    ST_DECIDE,
    ST_SNAP_GO,
    ST_SNAP_WAIT,
    ST_SNAP_END,
    ST_FINISH,
    ST_EMIT
  } pie_state_t;

  typedef struct packed {
    logic [1:0]               op;
    logic signed [POS_W-1:0]  pot_reading;
    logic signed [POS_W-1:0]  encoder_reading;
    logic signed [POS_W-1:0]  index_latch;
    logic [31:0]              pulse_count;
  } pie_in_t;

  typedef struct packed {
    logic signed [POS_W-1:0]  position;
    logic signed [POS_W-1:0]  filtered_position;
    logic                     is_zeroed;
    logic                     has_error;
  } pie_out_t;

  typedef struct packed {
    logic [6:0]               average_count;
    logic [30:0]              index_spacing;
    logic signed [31:0]       index_location;
    logic [30:0]              error_limit;
  } pie_cfg_t;

  typedef struct packed {
    logic         load_in;
    logic         calc_slot;
    logic         mod_store;
    logic         ram_read;
    logic         update;
    logic         div_start;
    pie_div_sel_t div_sel;
    logic         avg_store;
    logic         decide_store;
    logic         snap_store;
    logic         finish;
    logic         emit;
  } pie_cmd_t;

  typedef struct packed {
    pie_op_t in_op;
    logic    need_mod;
    logic    div_busy;
    logic    do_snap;
    logic    out_free;
  } pie_sts_t;

  // clamp a wide signed value to the position range
  function automatic logic signed [POS_W-1:0] sat_pos(input logic signed [SAT_W-1:0] v);
    logic signed [SAT_W-1:0] hi;
    logic signed [SAT_W-1:0] lo;
    hi = $signed({{(SAT_W-POS_W+1){1'b0}}, {(POS_W-1){1'b1}}});
    lo = ~hi;
    if (v > hi) begin
      return hi[POS_W-1:0];
    end else if (v < lo) begin
      return lo[POS_W-1:0];
    end
    return v[POS_W-1:0];
  endfunction

endpackage

`default_nettype wire

// ----- sv/pie_in_if.sv -----
// ----------------------------------------------------------------------------
// pie_in_if
// Valid/ready channel carrying one sample transaction.
// ----------------------------------------------------------------------------
`default_nettype none

interface pie_in_if;
  import pie_pkg::*;
  logic    valid;
  logic    ready;
  pie_in_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ----- sv/pie_out_if.sv -----
// ----------------------------------------------------------------------------
// pie_out_if
// Valid/ready channel carrying one result transaction.
// ----------------------------------------------------------------------------
`default_nettype none

interface pie_out_if;
  import pie_pkg::*;
  logic     valid;
  logic     ready;
  pie_out_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ----- sv/pot_index_zeroing_estimator_core.sv -----
// ----------------------------------------------------------------------------
// pot_index_zeroing_estimator_core
// Pot and index zeroing estimator with APB-style configuration registers.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries one transaction per sensor sample (op, pot, encoder,
//   latched encoder, pulse count); out_ch returns exactly one result per
//   accepted transaction, in order. Both are valid/ready channels.
//   Configuration is written through the cfg_ APB port; the user must write it
//   only while idle, which the block does not enforce. pready is tied high and
//   reads return the register contents. Error, restart and no-op transactions
//   go straight to the finish and emit states. A sample runs the divider for
//   the average, again when the offset is snapped to an index multiple, and
//   first for a modulo when the write slot must be reduced by a lowered average
//   count. The shared divider is DW = 33 + log2(MAX_AVG_SAMPLES) bits, 39 by
//   default, and yields one quotient bit per cycle. One transaction is in
//   work at a time; in_ch.ready is high while the sequencer waits for input.
//   A finished result sits in an output register; if out_ch is stalled the
//   next transaction is still taken and waits before its result is loaded.
//   Reset (rst_n low, synchronous) restores register defaults and clears the
//   estimator; no clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module pot_index_zeroing_estimator_core #(
  parameter int MAX_AVG_SAMPLES = pie_pkg::DEF_MAX_AVG
) (
  input  logic                       clk,
  input  logic                       rst_n,
  pie_in_if.sink                     in_ch,
  pie_out_if.source                  out_ch,
  input  logic                       cfg_psel,
  input  logic                       cfg_penable,
  input  logic                       cfg_pwrite,
  input  logic [pie_pkg::CFG_AW-1:0] cfg_paddr,
  input  logic [31:0]                cfg_pwdata,
  output logic [31:0]                cfg_prdata,
  output logic                       cfg_pready
);
  import pie_pkg::*;

  logic [6:0]         avg_count_r;
  logic [30:0]        spacing_r;
  logic signed [31:0] location_r;
  logic [30:0]        err_limit_r;
  logic               cfg_wr;
  pie_reg_t           cfg_sel;
  pie_cfg_t           cfg;
  pie_cmd_t           cmd;
  pie_sts_t           sts;
  logic               in_ready;

  // configuration registers
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_sel    = pie_reg_t'(cfg_paddr[3:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      avg_count_r <= RST_AVG_COUNT;
      spacing_r   <= RST_SPACING;
      location_r  <= RST_LOCATION;
      err_limit_r <= RST_ERR_LIMIT;
    end else if (cfg_wr) begin
      unique case (cfg_sel)
        REG_AVG_COUNT: avg_count_r <= cfg_pwdata[6:0];
        REG_SPACING:   spacing_r   <= cfg_pwdata[30:0];
        REG_LOCATION:  location_r  <= cfg_pwdata;
        REG_ERR_LIMIT: err_limit_r <= cfg_pwdata[30:0];
        default: begin
        end
      endcase
    end
  end

  // register read-back
  always_comb begin
    unique case (cfg_sel)
      REG_AVG_COUNT: cfg_prdata = {25'd0, avg_count_r};
      REG_SPACING:   cfg_prdata = {1'b0, spacing_r};
      REG_LOCATION:  cfg_prdata = location_r;
      REG_ERR_LIMIT: cfg_prdata = {1'b0, err_limit_r};
      default:       cfg_prdata = '0;
    endcase
  end

  assign cfg.average_count  = avg_count_r;
  assign cfg.index_spacing  = spacing_r;
  assign cfg.index_location = location_r;
  assign cfg.error_limit    = err_limit_r;

  pie_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  pie_dp #(.MAX_AVG_SAMPLES(MAX_AVG_SAMPLES)) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg         (cfg),
    .in_payload  (in_ch.payload),
    .cmd         (cmd),
    .sts         (sts),
    .out_valid   (out_ch.valid),
    .out_ready   (out_ch.ready),
    .out_payload (out_ch.payload)
  );

  assign in_ch.ready = in_ready;

  // the sequencer is busy right after taking a transaction
  `PIE_ASSERT(a_busy_after_accept, clk, rst_n, (in_ch.valid && in_ready) |=> !in_ready)
  // a pending result is never overwritten
  `PIE_NEVER(a_no_result_overwrite, clk, rst_n, cmd.emit && !sts.out_free)
  // the divider is only started when free
  `PIE_NEVER(a_div_start_idle, clk, rst_n, cmd.div_start && sts.div_busy)

endmodule

`default_nettype wire

// ----- sv/pie_ram.sv -----
// ----------------------------------------------------------------------------
// pie_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module pie_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ----- sv/pie_div.sv -----
// ----------------------------------------------------------------------------
// pie_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module pie_div #(
  parameter int W = 40
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  input  logic [W-1:0] dividend,
  input  logic [W-1:0] divisor,
  output logic         busy,
  output logic [W-1:0] quo,
  output logic [W-1:0] rem
);

  localparam int CW = $clog2(W + 1);

  logic [W-1:0]  rem_r, rem_nxt;
  logic [W-1:0]  quo_r, quo_nxt;
  logic [W-1:0]  dvs_r, dvs_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          busy_r, busy_nxt;
  logic [W:0]    rem_sh;
  logic [W:0]    diff;
  logic          ge;

  // one restoring step
  always_comb begin
    rem_sh   = {rem_r, quo_r[W-1]};
    ge       = rem_sh >= {1'b0, dvs_r};
    diff     = rem_sh - {1'b0, dvs_r};
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dvs_nxt  = dvs_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    if (start) begin
      rem_nxt  = '0;
      quo_nxt  = dividend;
      dvs_nxt  = divisor;
      cnt_nxt  = CW'(W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rem_nxt  = ge ? diff[W-1:0] : rem_sh[W-1:0];
      quo_nxt  = {quo_r[W-2:0], ge};
      cnt_nxt  = cnt_r - CW'(1);
      busy_nxt = cnt_r != CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dvs_r <= dvs_nxt;
  end

  assign busy = busy_r;
  assign quo  = quo_r;
  assign rem  = rem_r;

endmodule

`default_nettype wire

// ----- sv/pie_ctrl.sv -----
// ----------------------------------------------------------------------------
// pie_ctrl
// Sequencer of the estimator: steps one transaction through the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

module pie_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  pie_pkg::pie_sts_t sts,
  output pie_pkg::pie_cmd_t cmd
);
  import pie_pkg::*;

  pie_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state and commands
  always_comb begin
    state_nxt   = state_r;
    cmd         = '0;
    cmd.div_sel = DIV_AVG;
    in_ready    = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_nxt   = (sts.in_op == OP_SAMPLE) ? ST_CHECK : ST_FINISH;
        end
      end
      ST_CHECK: begin
        if (sts.need_mod) begin
          state_nxt = ST_MOD_GO;
        end else begin
          cmd.calc_slot = 1'b1;
          state_nxt     = ST_READ;
        end
      end
      ST_MOD_GO: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = DIV_MOD;
        state_nxt     = ST_MOD_WAIT;
      end
      ST_MOD_WAIT: begin
        if (!sts.div_busy) begin
          cmd.mod_store = 1'b1;
          state_nxt     = ST_READ;
        end
      end
      ST_READ: begin
        cmd.ram_read = 1'b1;
        state_nxt    = ST_UPDATE;
      end
      ST_UPDATE: begin
        cmd.update = 1'b1;
        state_nxt  = ST_AVG_GO;
      end
      ST_AVG_GO: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = DIV_AVG;
        state_nxt     = ST_AVG_WAIT;
      end
      ST_AVG_WAIT: begin
        if (!sts.div_busy) begin
          state_nxt = ST_AVG_END;
        end
      end
      ST_AVG_END: begin
        cmd.avg_store = 1'b1;
        state_nxt     = ST_DECIDE;
      end
      ST_DECIDE: begin
        cmd.decide_store = 1'b1;
        state_nxt        = sts.do_snap ? ST_SNAP_GO : ST_FINISH;
      end
      ST_SNAP_GO: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = DIV_SNAP;
        state_nxt     = ST_SNAP_WAIT;
      end
      ST_SNAP_WAIT: begin
        if (!sts.div_busy) begin
          state_nxt = ST_SNAP_END;
        end
      end
      ST_SNAP_END: begin
        cmd.snap_store = 1'b1;
        state_nxt      = ST_FINISH;
      end
      ST_FINISH: begin
        cmd.finish = 1'b1;
        state_nxt  = ST_EMIT;
      end
      ST_EMIT: begin
        // hold until the output register is free
        if (sts.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ----- sv/pie_dp.sv -----
// ----------------------------------------------------------------------------
// pie_dp
// Datapath: sample ring, running sum, shared divider, offset and flags.
// ----------------------------------------------------------------------------
`default_nettype none

module pie_dp #(
  parameter int MAX_AVG_SAMPLES = pie_pkg::DEF_MAX_AVG
) (
  input  logic              clk,
  input  logic              rst_n,
  input  pie_pkg::pie_cfg_t cfg,
  input  pie_pkg::pie_in_t  in_payload,
  input  pie_pkg::pie_cmd_t cmd,
  output pie_pkg::pie_sts_t sts,
  output logic              out_valid,
  input  logic              out_ready,
  output pie_pkg::pie_out_t out_payload
);
  import pie_pkg::*;

  localparam int AW = (MAX_AVG_SAMPLES > 1) ? $clog2(MAX_AVG_SAMPLES) : 1;
  localparam int NW = $clog2(MAX_AVG_SAMPLES + 1);
  localparam int TW = POS_W + $clog2(MAX_AVG_SAMPLES) + 1;
  localparam int XW = POS_W + 2;
  localparam int DW = (TW > XW) ? TW : XW;

  pie_in_t                 in_r;
  logic signed [TW-1:0]    total_r, total_nxt;
  logic [NW-1:0]           fill_r, fill_nxt;
  logic [AW-1:0]           ws_r, ws_nxt;
  logic [AW-1:0]           wsm_r;
  logic [AW-1:0]           slot_r;
  logic signed [POS_W-1:0] avg_r;
  logic signed [XW-1:0]    x_r;
  logic signed [POS_W-1:0] snap_r;
  logic signed [POS_W-1:0] offset_r, offset_nxt;
  logic signed [POS_W-1:0] first_r, first_nxt;
  logic [31:0]             last_r, last_nxt;
  logic                    awaiting_r, awaiting_nxt;
  logic                    zeroed_r, zeroed_nxt;
  logic                    error_r, error_nxt;
  logic                    out_valid_r;
  pie_out_t                out_r;

  logic [NW-1:0]           n;
  logic [30:0]             s_eff;
  logic                    full, same_p, keep, do_snap, filling;
  logic signed [POS_W-1:0] samp_v;
  logic signed [POS_W-1:0] old_v;
  logic [POS_W-1:0]        rd_data;
  logic [NW-1:0]           ws_inc;
  logic [TW-1:0]           tot_abs;
  logic [XW-1:0]           x_abs;
  logic [DW-1:0]           dvd, dvs, quo, rem;
  logic                    div_busy;
  logic [30:0]             r_s;
  logic                    round_up;
  logic [XW:0]             snapped;
  logic signed [SAT_W-1:0] snapped_s;
  logic signed [SAT_W-1:0] snap_val;
  logic signed [POS_W-1:0] snap_off;
  logic signed [POS_W:0]   drift;
  logic [POS_W-1:0]        drift_abs;
  logic [TW-1:0]           avg_q;

  // effective average count and spacing
  always_comb begin
    if (cfg.average_count == 7'd0) begin
      n = NW'(1);
    end else if (int'(cfg.average_count) > MAX_AVG_SAMPLES) begin
      n = NW'(MAX_AVG_SAMPLES);
    end else begin
      n = NW'(cfg.average_count);
    end
    s_eff = (cfg.index_spacing == 31'd0) ? 31'd1 : cfg.index_spacing;
  end

  // zeroing decision
  assign full    = fill_r >= n;
  assign filling = fill_r < n;
  assign same_p  = in_r.pulse_count == last_r;
  assign keep    = !zeroed_r && (same_p || !full);
  assign do_snap = !keep && (!zeroed_r || !same_p);

  assign samp_v = sat_pos(SAT_W'(in_r.pot_reading) - SAT_W'(in_r.encoder_reading));
  assign old_v  = $signed(rd_data);
  assign ws_inc = NW'(wsm_r) + NW'(1);

  assign sts.in_op    = pie_op_t'(in_payload.op);
  assign sts.need_mod = NW'(ws_r) >= n;
  assign sts.div_busy = div_busy;
  assign sts.do_snap  = do_snap;
  assign sts.out_free = !out_valid_r || out_ready;

  // sample ring
  pie_ram #(.WIDTH(POS_W), .DEPTH(MAX_AVG_SAMPLES)) u_ring (
    .clk     (clk),
    .wr_en   (cmd.update),
    .wr_addr (slot_r),
    .wr_data (samp_v),
    .rd_en   (cmd.ram_read),
    .rd_addr (slot_r),
    .rd_data (rd_data)
  );

  // divider operand selection
  assign tot_abs = total_r[TW-1] ? TW'(-total_r) : TW'(total_r);
  assign x_abs   = x_r[XW-1] ? XW'(-x_r) : XW'(x_r);

  always_comb begin
    case (cmd.div_sel)
      DIV_MOD: begin
        dvd = DW'(ws_r);
        dvs = DW'(n);
      end
      DIV_AVG: begin
        dvd = DW'(tot_abs);
        dvs = DW'(fill_r);
      end
      DIV_SNAP: begin
        dvd = DW'(x_abs);
        dvs = DW'(s_eff);
      end
      default: begin
        dvd = DW'(tot_abs);
        dvs = DW'(fill_r);
      end
    endcase
  end

  pie_div #(.W(DW)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (dvd),
    .divisor  (dvs),
    .busy     (div_busy),
    .quo      (quo),
    .rem      (rem)
  );

  // round the index distance half away from zero
  always_comb begin
    r_s       = rem[30:0];
    round_up  = {r_s, 1'b0} >= {1'b0, s_eff};
    snapped   = (XW+1)'(x_abs) - (XW+1)'(r_s) + (round_up ? (XW+1)'(s_eff) : '0);
    snapped_s = $signed(SAT_W'(snapped));
    snap_val  = x_r[XW-1] ? -snapped_s : snapped_s;
    snap_off  = sat_pos(snap_val - SAT_W'(in_r.index_latch) + SAT_W'(cfg.index_location));
    avg_q     = TW'(quo);
  end

  // drift against the first snapped offset
  assign drift     = (POS_W+1)'(first_r) - (POS_W+1)'(snap_r);
  assign drift_abs = drift[POS_W] ? POS_W'(-drift) : POS_W'(drift);

  // estimator state update
  always_comb begin
    total_nxt    = total_r;
    fill_nxt     = fill_r;
    ws_nxt       = ws_r;
    offset_nxt   = offset_r;
    first_nxt    = first_r;
    last_nxt     = last_r;
    awaiting_nxt = awaiting_r;
    zeroed_nxt   = zeroed_r;
    error_nxt    = error_r;
    if (cmd.update) begin
      total_nxt = filling ? total_r + TW'(samp_v) : total_r - TW'(old_v) + TW'(samp_v);
      if (filling) begin
        fill_nxt = fill_r + NW'(1);
      end
      ws_nxt = (ws_inc == n) ? '0 : AW'(ws_inc);
      if (awaiting_r) begin
        last_nxt     = in_r.pulse_count;
        awaiting_nxt = 1'b0;
      end
    end
    if (cmd.finish) begin
      case (pie_op_t'(in_r.op))
        OP_ERROR: begin
          error_nxt = 1'b1;
        end
        OP_RESTART: begin
          total_nxt    = '0;
          fill_nxt     = '0;
          ws_nxt       = '0;
          offset_nxt   = '0;
          first_nxt    = '0;
          last_nxt     = '0;
          awaiting_nxt = 1'b1;
          zeroed_nxt   = 1'b0;
          error_nxt    = 1'b0;
        end
        OP_SAMPLE: begin
          if (keep) begin
            offset_nxt = avg_r;
          end else if (do_snap) begin
            offset_nxt = snap_r;
            last_nxt   = in_r.pulse_count;
            zeroed_nxt = 1'b1;
            if (!zeroed_r) begin
              first_nxt = snap_r;
            end else if (drift_abs > POS_W'(cfg.error_limit)) begin
              error_nxt = 1'b1;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r     <= '0;
      fill_r      <= '0;
      ws_r        <= '0;
      offset_r    <= '0;
      first_r     <= '0;
      last_r      <= '0;
      awaiting_r  <= 1'b1;
      zeroed_r    <= 1'b0;
      error_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      total_r    <= total_nxt;
      fill_r     <= fill_nxt;
      ws_r       <= ws_nxt;
      offset_r   <= offset_nxt;
      first_r    <= first_nxt;
      last_r     <= last_nxt;
      awaiting_r <= awaiting_nxt;
      zeroed_r   <= zeroed_nxt;
      error_r    <= error_nxt;
      // drop the result once taken, raise it on a new one
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      in_r <= in_payload;
    end
    if (cmd.calc_slot) begin
      wsm_r  <= ws_r;
      slot_r <= filling ? AW'(fill_r) : ws_r;
    end
    if (cmd.mod_store) begin
      wsm_r  <= AW'(rem);
      slot_r <= filling ? AW'(fill_r) : AW'(rem);
    end
    if (cmd.avg_store) begin
      avg_r <= total_r[TW-1] ? POS_W'(-avg_q) : POS_W'(avg_q);
    end
    if (cmd.decide_store) begin
      x_r <= XW'(avg_r) + XW'(in_r.index_latch) - XW'(cfg.index_location);
    end
    if (cmd.snap_store) begin
      snap_r <= snap_off;
    end
    if (cmd.emit) begin
      if (pie_op_t'(in_r.op) == OP_SAMPLE) begin
        out_r.position          <= sat_pos(SAT_W'(offset_r) + SAT_W'(in_r.encoder_reading));
        out_r.filtered_position <= sat_pos(SAT_W'(avg_r) + SAT_W'(in_r.encoder_reading));
      end else begin
        out_r.position          <= '0;
        out_r.filtered_position <= '0;
      end
      out_r.is_zeroed <= zeroed_r;
      out_r.has_error <= error_r;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_payload = out_r;

endmodule

`default_nettype wire

// ----- sim/pot_index_zeroing_estimator_core_test.sv -----
// ----------------------------------------------------------------------------
// pot_index_zeroing_estimator_core_test
// Self-checking testbench for the pot and index zeroing estimator. An
// in-bench offset estimator predicts every result. Directed transactions and
// randomised sample streams run under several register settings, with random
// gaps and stalls on both channels.
// ----------------------------------------------------------------------------
`default_nettype none

module pot_index_zeroing_estimator_core_test;
  import pie_pkg::*;

  localparam int RING_DEPTH = 64;
  localparam int IDLE_LIMIT = 6000;

  // offset estimator with its own register copy and expected-result store
  class estimator_scoreboard;
    int unsigned avg_count;
    int unsigned spacing;
    longint      location;
    longint      err_limit;
    longint      ring [RING_DEPTH];
    int unsigned fill;
    int unsigned wslot;
    longint      offset;
    longint      first_offset;
    bit [31:0]   last_pulses;
    bit          awaiting;
    bit          zeroed;
    bit          err;
    pie_out_t    pending [$];
    int          errors;
    int          checked;
    int          snaps;

    function void clear_estimate();
      fill = 0; wslot = 0; offset = 0; first_offset = 0;
      last_pulses = 0; awaiting = 1; zeroed = 0; err = 0;
    endfunction

    function void defaults();
      avg_count = RST_AVG_COUNT;
      spacing   = RST_SPACING;
      location  = 0;
      err_limit = RST_ERR_LIMIT;
      clear_estimate();
    endfunction

    function void set_reg(pie_reg_t idx, logic [31:0] val);
      case (idx)
        REG_AVG_COUNT: avg_count = val[6:0];
        REG_SPACING:   spacing   = val[30:0];
        REG_LOCATION:  location  = longint'($signed(val));
        REG_ERR_LIMIT: err_limit = longint'(val[30:0]);
      endcase
    endfunction

    function longint clamp(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
    endfunction

    // snap to the nearest index multiple, half away from zero
    function longint snap(longint avg, longint latched);
      longint s, x, ax, q, r;
      s  = (spacing == 0) ? 1 : longint'(spacing);
      x  = avg + latched - location;
      ax = (x < 0) ? -x : x;
      q  = (2 * ax + s) / (2 * s);
      r  = q * s;
      if (x < 0) r = -r;
      return clamp(r - latched + location);
    endfunction

    // note an accepted input and queue its expected result
    function void note_input(pie_in_t it);
      pie_out_t    res;
      int unsigned n, slot;
      longint      pot, enc, lat, total, avg, d;
      bit          full;
      pot = longint'($signed(it.pot_reading));
      enc = longint'($signed(it.encoder_reading));
      lat = longint'($signed(it.index_latch));
      res = '0;
      case (pie_op_t'(it.op))
        OP_ERROR:   err = 1;
        OP_RESTART: clear_estimate();
        OP_SAMPLE: begin
          n = (avg_count < 1) ? 1 : (avg_count > RING_DEPTH) ? RING_DEPTH : avg_count;
          if (awaiting) begin
            last_pulses = it.pulse_count;
            awaiting = 0;
          end
          if (fill < n) begin
            slot = fill;
            fill++;
          end else begin
            slot = wslot % n;
          end
          ring[slot % RING_DEPTH] = clamp(pot - enc);
          wslot = ((wslot % n) + 1) % n;
          total = 0;
          for (int i = 0; i < fill && i < RING_DEPTH; i++) total += ring[i];
          avg  = total / longint'(fill);
          full = fill >= n;
          if (!zeroed && (it.pulse_count == last_pulses || !full)) begin
            offset = avg;
          end else if (!zeroed || it.pulse_count != last_pulses) begin
            offset = snap(avg, lat);
            snaps++;
            last_pulses = it.pulse_count;
            if (!zeroed) first_offset = offset;
            zeroed = 1;
            d = first_offset - offset;
            if (d < 0) d = -d;
            if (d > err_limit) err = 1;
          end
          res.position          = 32'(clamp(offset + enc));
          res.filtered_position = 32'(clamp(avg + enc));
        end
        default: ;
      endcase
      res.is_zeroed = zeroed;
      res.has_error = err;
      pending = {pending, res};
    endfunction

    task report(string msg);
      $display("MISMATCH: %s", msg);
      errors++;
    endtask

    // compare one result against the oldest expectation
    task check_result(pie_out_t got);
      pie_out_t want;
      if (pending.size() == 0) begin
        report("result with no transaction outstanding");
        return;
      end
      want = pending.pop_front();
      checked++;
      if (got.position !== want.position)
        report($sformatf("position got %0d want %0d", got.position, want.position));
      if (got.filtered_position !== want.filtered_position)
        report($sformatf("filtered_position got %0d want %0d",
                         got.filtered_position, want.filtered_position));
      if (got.is_zeroed !== want.is_zeroed)
        report($sformatf("is_zeroed got %b want %b", got.is_zeroed, want.is_zeroed));
      if (got.has_error !== want.has_error)
        report($sformatf("has_error got %b want %b", got.has_error, want.has_error));
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst_n;
  logic        cfg_psel, cfg_penable, cfg_pwrite, cfg_pready;
  logic [CFG_AW-1:0] cfg_paddr;
  logic [31:0] cfg_pwdata, cfg_prdata;

  pie_in_if  in_ch ();
  pie_out_if out_ch ();

  estimator_scoreboard sb;
  bit          rx_idling;
  int          hold_request;
  int          hold_served;
  int          hold_left;
  int          stall_left;
  int          quiet_cycles;
  int          sent;
  bit [31:0]   pulses;
  longint      true_offset;

  always #6 clk = ~clk;

  pot_index_zeroing_estimator_core uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  // receiver: check results, drive ready with random and requested stalls
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) sb.check_result(out_ch.payload);
      if (hold_request != hold_served) begin
        hold_served = hold_request;
        hold_left = 400;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
        if (rx_idling && $urandom_range(0, 3) == 0)
          stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 80)
                                                   : $urandom_range(1, 3);
      end
    end
  end

  // watchdog: give up after a long stretch with no transaction either side
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || !rst_n)
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles > IDLE_LIMIT) begin
      $display("timeout with %0d results outstanding", sb.pending.size());
      $display("DONE: errors detected");
      $finish;
    end
  end

  // offer one transaction, after an optional gap, and hold until taken
  task send(pie_in_t it, bit gaps);
    int gap;
    gap = 0;
    if (gaps && $urandom_range(0, 2) == 0)
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 60) : $urandom_range(1, 4);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.payload <= it;
    in_ch.valid   <= 1'b1;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_input(it);
    sent++;
  endtask

  task go_idle();
    in_ch.valid <= 1'b0;
    while (sb.pending.size() > 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // register write: setup cycle then access cycle
  task write_reg(pie_reg_t idx, logic [31:0] val);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= CFG_AW'({idx, 2'b00});
    cfg_pwdata  <= val;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    sb.set_reg(idx, val);
  endtask

  function pie_in_t item(pie_op_t op, logic [31:0] pot, logic [31:0] enc,
                         logic [31:0] lat, logic [31:0] pc);
    pie_in_t it;
    it.op = op; it.pot_reading = pot; it.encoder_reading = enc;
    it.index_latch = lat; it.pulse_count = pc;
    return it;
  endfunction

  // plausible sample: pot tracks encoder plus a fixed offset, pulses step
  function pie_in_t plausible();
    longint enc, pot;
    enc = longint'($signed($urandom_range(0, 32'h00FF_FFFF))) - 64'sd8388608;
    pot = enc + true_offset + longint'($urandom_range(0, 4000)) - 2000;
    if ($urandom_range(0, 5) == 0) pulses = pulses + 1;
    return item(OP_SAMPLE, pot[31:0], enc[31:0], $urandom_range(0, 32'h0FFF_FFFF), pulses);
  endfunction

  // noise: raw fields and stray ops
  function pie_in_t noise();
    int unsigned r;
    r = $urandom_range(0, 19);
    return item((r == 0) ? OP_ERROR : (r == 1) ? OP_NONE : OP_SAMPLE,
                $urandom, $urandom, $urandom, (r < 10) ? $urandom : pulses);
  endfunction

  initial begin
    sb = new();
    sb.defaults();
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.payload = '0;
    cfg_psel = 1'b0; cfg_penable = 1'b0; cfg_pwrite = 1'b0;
    cfg_paddr = '0; cfg_pwdata = '0;
    rx_idling = 1'b1;
    hold_request = 0; hold_served = 0; hold_left = 0; stall_left = 0;
    quiet_cycles = 0; sent = 0; pulses = 0; true_offset = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: saturation, every op, reset register values
    send(item(OP_SAMPLE, 32'h7FFF_FFFF, 32'h8000_0000, 0, 5), 0);
    send(item(OP_SAMPLE, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 5), 0);
    send(item(OP_NONE, 32'hFFFF_FFFF, 1, 2, 32'hFFFF_FFFF), 0);
    send(item(OP_ERROR, 0, 0, 0, 0), 0);
    send(item(OP_RESTART, 0, 0, 0, 0), 0);
    go_idle();

    // directed: small ring, snap on pulse change, then lowered count
    write_reg(REG_AVG_COUNT, 2);
    write_reg(REG_SPACING, 32'h0001_0000);
    write_reg(REG_ERR_LIMIT, 0);
    send(item(OP_SAMPLE, 32'h0001_8000, 0, 0, 7), 0);
    send(item(OP_SAMPLE, 32'h0001_8000, 0, 0, 7), 0);
    send(item(OP_SAMPLE, 32'hFFFE_8000, 0, 0, 8), 0);
    send(item(OP_SAMPLE, 32'h0003_0000, 32'h0000_1000, 32'h0002_0000, 9), 0);
    go_idle();
    write_reg(REG_AVG_COUNT, 1);
    write_reg(REG_SPACING, 0);
    write_reg(REG_LOCATION, 32'h8000_0000);
    send(item(OP_SAMPLE, 32'h0000_1234, 0, 32'h7FFF_FFFF, 10), 0);
    send(item(OP_SAMPLE, 32'hFFFF_0000, 5, 32'h8000_0000, 11), 0);
    go_idle();
    write_reg(REG_AVG_COUNT, 0);
    write_reg(REG_LOCATION, 32'h7FFF_FFFF);
    write_reg(REG_ERR_LIMIT, 32'h7FFF_FFFF);
    send(item(OP_RESTART, 0, 0, 0, 0), 0);
    send(item(OP_SAMPLE, 32'h0000_0003, 1, 0, 3), 0);
    send(item(OP_SAMPLE, 32'hFFFF_FFFD, 1, 0, 4), 0);
    go_idle();
    write_reg(REG_AVG_COUNT, 7'h7F);
    send(item(OP_SAMPLE, 32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA), 0);
    go_idle();

    // random phases under varied register settings
    for (int ph = 0; ph < 8; ph++) begin
      write_reg(REG_AVG_COUNT, (ph == 3) ? 64 : (ph == 5) ? 7'h7F : $urandom_range(1, 8));
      write_reg(REG_SPACING, (ph == 1) ? 32'h7FFF_FFFF : (ph == 2) ? 1
                             : $urandom_range(32'h0000_1000, 32'h0010_0000));
      write_reg(REG_LOCATION, (ph == 4) ? 32'h8000_0000 : $urandom_range(0, 32'h000F_FFFF));
      write_reg(REG_ERR_LIMIT, (ph == 6) ? 0 : (ph == 7) ? 32'h7FFF_FFFF
                               : $urandom_range(0, 32'h0002_0000));
      true_offset = longint'($urandom_range(0, 32'h00FF_FFFF)) - 64'sd8388608;
      rx_idling = (ph != 0);
      send(item(OP_RESTART, 0, 0, 0, 0), 0);
      for (int k = 0; k < 55; k++) begin
        if (ph == 2 && k == 10) hold_request++;
        if (ph == 4 && k == 30) go_idle();
        if (k % 20 == 19 && $urandom_range(0, 1) == 0)
          send(item(OP_RESTART, 0, 0, 0, 0), 1);
        else if ($urandom_range(0, 9) < 8)
          send(plausible(), ph != 0);
        else
          send(noise(), ph != 0);
      end
      go_idle();
    end

    repeat (50) @(posedge clk);
    $display("covered %0d transactions, %0d results checked, %0d index snaps",
             sent, sb.checked, sb.snaps);
    $display("eight register settings including range extremes, long receiver hold");
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ----- filelist.f -----
+incdir+sv
sv/pie_pkg.sv
sv/pie_in_if.sv
sv/pie_out_if.sv
sv/pie_ram.sv
sv/pie_div.sv
sv/pie_ctrl.sv
sv/pie_dp.sv
sv/pot_index_zeroing_estimator_core.sv
sim/pot_index_zeroing_estimator_core_test.sv
